// ===== hw/rtl/mfcip_pkg.sv =====
// ----------------------------------------------------------------------------
// mfcip_pkg: shared types and constants of the marker framed CSV parser
// Character codes, piece phase codes and the held value type.
// ----------------------------------------------------------------------------
`default_nettype none

package mfcip_pkg;

	// Held field value
	typedef logic signed [15:0] field_t;

	// Number of fields kept per frame
	localparam int unsigned NumFields = 4;

	// Framing and separator characters
	localparam logic [7:0] CH_START = 8'h3C;	// '<'
	localparam logic [7:0] CH_END   = 8'h3E;	// '>'
	localparam logic [7:0] CH_COMMA = 8'h2C;	// ','
	localparam logic [7:0] CH_PLUS  = 8'h2B;	// '+'
	localparam logic [7:0] CH_MINUS = 8'h2D;	// '-'
	localparam logic [7:0] CH_ZERO  = 8'h30;	// '0'
	localparam logic [7:0] CH_NINE  = 8'h39;	// '9'
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;	// first of tab .. carriage return
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Piece phase codes
	localparam logic [2:0] PH_BETWEEN = 3'd0;
	localparam logic [2:0] PH_LEADING = 3'd1;
	localparam logic [2:0] PH_SIGNED  = 3'd2;
	localparam logic [2:0] PH_DIGITS  = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	// Magnitude ceiling: one past the largest positive value
	localparam logic [15:0] MAG_LIMIT = 16'd32768;
	localparam logic [15:0] POS_MAX   = 16'd32767;

endpackage

`default_nettype wire

// ===== hw/rtl/marker_framed_csv_integer_parser_top.sv =====
// ----------------------------------------------------------------------------
// marker_framed_csv_integer_parser_top: framed CSV integer parser
// Parses '<'..'>' frames of comma separated integers into four held
// 16-bit values and reports them once per frame.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------------
//  rx       | rx_valid / rx_ready        | rx_byte
//  result   | result_valid / result_ready| throttle/pitch/yaw/roll_value,
//           |                            | pieces_found
//
//  One byte is accepted per cycle while the input register is not stalled.
//  A byte is held in the input register, is parsed there against the frame
//  state and, for '>', is written to the result register, which raises
//  result_valid with that write.
//  Reset clears frame state and held values; no clearing pass is needed.
//  A '>' waiting on a full result register stalls the input register and with
//  it rx_ready; every other byte moves on regardless of the result side.
//
`default_nettype none

module marker_framed_csv_integer_parser_top
	import mfcip_pkg::*;
#(
	parameter int unsigned MAX_CONTENT_CHARS = 31
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic signed [15:0]      throttle_value,
	output logic signed [15:0]      pitch_value,
	output logic signed [15:0]      yaw_value,
	output logic signed [15:0]      roll_value,
	output logic [2:0]              pieces_found
);

	localparam int unsigned CW = $clog2(MAX_CONTENT_CHARS + 1);
	localparam logic [CW-1:0] CountMax = CW'(MAX_CONTENT_CHARS);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Frame and piece state
	logic          in_frame_q;
	logic [CW-1:0] count_q;
	logic          ended_q;
	logic [2:0]    idx_q;
	logic [2:0]    phase_q;
	logic          neg_q;
	logic [15:0]   acc_q;
	field_t        held_q [NumFields];

	// Next state
	logic          in_frame_d;
	logic [CW-1:0] count_d;
	logic          ended_d;
	logic [2:0]    idx_d;
	logic [2:0]    phase_d;
	logic          neg_d;
	logic [15:0]   acc_d;
	field_t        held_d [NumFields];

	// Values after closing the current piece
	field_t piece_val;
	field_t fin_held [NumFields];
	logic [2:0] fin_idx;

	logic        is_end;
	logic        emit;
	logic        go_s1;
	logic        is_space;
	logic        is_digit;
	logic [18:0] acc_mul;
	logic [15:0] acc_add;
	logic [16:0] neg_ext;

	// Classify the held byte
	assign is_end   = byte_s1 == CH_END;
	assign emit     = valid_s1 && in_frame_q && is_end;
	assign go_s1    = valid_s1 && (!emit || !result_valid || result_ready);
	assign rx_ready = !valid_s1 || go_s1;

	assign is_space = (byte_s1 == CH_SPACE) || (byte_s1 >= CH_TAB && byte_s1 <= CH_CR);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

	// Accumulate one decimal digit, saturating at the magnitude ceiling
	assign acc_mul = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
		+ {15'd0, 4'(byte_s1 - CH_ZERO)};
	assign acc_add = (acc_mul > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : acc_mul[15:0];

	// Signed value of the current piece
	assign neg_ext = 17'd0 - {1'b0, acc_q};
	assign piece_val = neg_q ? field_t'(neg_ext[15:0])
		: field_t'((acc_q > POS_MAX) ? POS_MAX : acc_q);

	// Close the current piece into the held values
	always_comb begin
		for (int k = 0; k < NumFields; k++) begin
			fin_held[k] = held_q[k];
		end
		fin_idx = idx_q;
		if (phase_q != PH_BETWEEN && idx_q < 3'(NumFields)) begin
			fin_held[idx_q[1:0]] = piece_val;
			fin_idx = idx_q + 3'd1;
		end
	end

	// Parse one byte against the frame state
	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		ended_d    = ended_q;
		idx_d      = idx_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		for (int k = 0; k < NumFields; k++) begin
			held_d[k] = held_q[k];
		end
		priority if (!in_frame_q) begin
			// outside a frame only the start marker counts
			if (byte_s1 == CH_START) begin
				in_frame_d = 1'b1;
				count_d    = '0;
				ended_d    = 1'b0;
				idx_d      = 3'd0;
				phase_d    = PH_BETWEEN;
				neg_d      = 1'b0;
				acc_d      = '0;
			end
		end else if (is_end) begin
			// close the frame
			for (int k = 0; k < NumFields; k++) begin
				held_d[k] = fin_held[k];
			end
			in_frame_d = 1'b0;
			count_d    = '0;
			ended_d    = 1'b0;
			idx_d      = 3'd0;
			phase_d    = PH_BETWEEN;
			neg_d      = 1'b0;
			acc_d      = '0;
		end else if (!ended_q && count_q < CountMax) begin
			count_d = count_q + CW'(1);
			priority if (byte_s1 == CH_NUL) begin
				ended_d = 1'b1;
			end else if (byte_s1 == CH_COMMA) begin
				for (int k = 0; k < NumFields; k++) begin
					held_d[k] = fin_held[k];
				end
				idx_d   = fin_idx;
				phase_d = PH_BETWEEN;
				neg_d   = 1'b0;
				acc_d   = '0;
			end else begin
				unique case (phase_q)
					PH_BETWEEN, PH_LEADING: begin
						priority if (is_space) begin
							phase_d = PH_LEADING;
						end else if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
							neg_d   = byte_s1 == CH_MINUS;
							phase_d = PH_SIGNED;
						end else if (is_digit) begin
							acc_d   = acc_add;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_DONE;
						end
					end
					PH_SIGNED, PH_DIGITS: begin
						if (is_digit) begin
							acc_d   = acc_add;
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_DONE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end else begin
			// drop bytes past the content limit or after a zero byte
			ended_d = ended_q;
		end
	end

	// Input register: load when empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state: advance on every parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			ended_q    <= 1'b0;
			idx_q      <= 3'd0;
			phase_q    <= PH_BETWEEN;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			for (int k = 0; k < NumFields; k++) begin
				held_q[k] <= '0;
			end
		end else if (go_s1) begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			ended_q    <= ended_d;
			idx_q      <= idx_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			for (int k = 0; k < NumFields; k++) begin
				held_q[k] <= held_d[k];
			end
		end
	end

	// Result register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (go_s1 && emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			throttle_value <= fin_held[0];
			pitch_value    <= fin_held[1];
			yaw_value      <= fin_held[2];
			roll_value     <= fin_held[3];
			pieces_found   <= fin_idx;
		end
	end

	// Checks
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (idx_q == 3'd0 && phase_q == PH_BETWEEN && count_q == '0))
		else $error("frame state not cleared outside a frame");

	a_idx_cap: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'(NumFields))
		else $error("piece index above field count");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountMax)
		else $error("content count above limit");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1 && in_frame_q && is_end))
		else $error("result without end marker");

endmodule

`default_nettype wire

// ===== verif/mfcip_frame_checker.sv =====
// ----------------------------------------------------------------------------
// mfcip_frame_checker: frame result checker for the framed CSV parser
// Watches the byte and result channels and tracks frame state and held
// values byte by byte. Compares every result transaction with the oldest
// expected frame, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcip_frame_checker
	import mfcip_pkg::*;
#(
	parameter int unsigned MAX_CONTENT_CHARS = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	input  wire logic          rx_ready,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          result_valid,
	input  wire logic          result_ready,
	input  wire field_t        throttle_value,
	input  wire field_t        pitch_value,
	input  wire field_t        yaw_value,
	input  wire field_t        roll_value,
	input  wire logic [2:0]    pieces_found,
	output int unsigned        mismatch_count,
	output int unsigned        frames_outstanding
);

	typedef struct {
		field_t     throttle;
		field_t     pitch;
		field_t     yaw;
		field_t     roll;
		logic [2:0] pieces;
	} frame_values_t;

	frame_values_t expected_frames [$];

	// Parser state as it stands after every accepted byte
	logic        in_frame        = 1'b0;
	int unsigned content_len     = 0;
	logic        content_stopped = 1'b0;
	int unsigned piece_idx       = 0;
	logic [2:0]  phase           = PH_BETWEEN;
	logic        negative        = 1'b0;
	logic [15:0] magnitude       = '0;
	field_t      held [NumFields] = '{default: '0};

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Append one decimal digit, saturating the magnitude one past the top
	function automatic logic [15:0] next_magnitude(input logic [15:0] m, input logic [7:0] c);
		int unsigned sum;
		sum = int'(m) * 10 + int'(c - CH_ZERO);
		return sum > MAG_LIMIT ? MAG_LIMIT : sum[15:0];
	endfunction

	// Store the piece under way into its slot, if one is left, and start a new one
	function automatic void close_piece();
		int v;
		if (phase == PH_BETWEEN)
			return;
		if (negative)
			v = -int'(magnitude);
		else
			v = magnitude > POS_MAX ? int'(POS_MAX) : int'(magnitude);
		if (piece_idx < NumFields) begin
			held[piece_idx] = field_t'(v);
			piece_idx++;
		end
		phase = PH_BETWEEN;
		negative = 1'b0;
		magnitude = '0;
	endfunction

	function automatic void restart_frame(input logic opening);
		in_frame = opening;
		content_len = 0;
		content_stopped = 1'b0;
		piece_idx = 0;
		phase = PH_BETWEEN;
		negative = 1'b0;
		magnitude = '0;
	endfunction

	// Advance the piece parser by one content byte
	function automatic void parse_content(input logic [7:0] c);
		if (c == CH_COMMA) begin
			close_piece();
			return;
		end
		if (phase == PH_BETWEEN) begin
			phase = PH_LEADING;
			negative = 1'b0;
			magnitude = '0;
		end
		case (phase)
			PH_LEADING: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					negative = (c == CH_MINUS);
					phase = PH_SIGNED;
				end else if (is_numeral(c)) begin
					magnitude = next_magnitude(magnitude, c);
					phase = PH_DIGITS;
				end else if (!is_blank(c)) begin
					phase = PH_DONE;
				end
			end
			PH_SIGNED, PH_DIGITS: begin
				if (is_numeral(c)) begin
					magnitude = next_magnitude(magnitude, c);
					phase = PH_DIGITS;
				end else begin
					phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Track one accepted byte; queue the frame values when it closes a frame
	function automatic void take_byte(input logic [7:0] c);
		frame_values_t f;
		if (!in_frame) begin
			if (c == CH_START)
				restart_frame(1'b1);
			return;
		end
		if (c != CH_END) begin
			if (!content_stopped && content_len < MAX_CONTENT_CHARS) begin
				content_len++;
				if (c == CH_NUL)
					content_stopped = 1'b1;
				else
					parse_content(c);
			end
			return;
		end
		close_piece();
		f.throttle = held[0];
		f.pitch = held[1];
		f.yaw = held[2];
		f.roll = held[3];
		f.pieces = 3'(piece_idx);
		expected_frames.push_back(f);
		restart_frame(1'b0);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Check results first so a frame closing on this edge cannot match early
	always @(posedge clk) begin
		frame_values_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_frames.size() == 0) begin
					report_mismatch("result transaction with no frame pending");
				end else begin
					want = expected_frames.pop_front();
					compare_field("throttle_value", throttle_value, want.throttle);
					compare_field("pitch_value", pitch_value, want.pitch);
					compare_field("yaw_value", yaw_value, want.yaw);
					compare_field("roll_value", roll_value, want.roll);
					compare_field("pieces_found", pieces_found, want.pieces);
				end
			end
			if (rx_valid && rx_ready)
				take_byte(rx_byte);
		end
		frames_outstanding = expected_frames.size();
	end

endmodule

`default_nettype wire

// ===== verif/marker_framed_csv_integer_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// marker_framed_csv_integer_parser_top_tb: testbench of the framed CSV parser
// Feeds directed frames, then random frames mixed with noise and broken
// frames, with random gaps on both channels, a stretch with no gaps and a
// long result back-pressure. The checker predicts and compares each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_framed_csv_integer_parser_top_tb;
	import mfcip_pkg::*;

	localparam int unsigned CONTENT_CHARS = 31;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned GAP_PCT       = 38;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        rx_valid     = 1'b0;
	logic [7:0]  rx_byte      = '0;
	logic        result_ready = 1'b0;
	logic        rx_ready;
	logic        result_valid;
	field_t      throttle_value;
	field_t      pitch_value;
	field_t      yaw_value;
	field_t      roll_value;
	logic [2:0]  pieces_found;

	int unsigned mismatch_count;
	int unsigned frames_outstanding;
	int unsigned cycle_count   = 0;
	int unsigned sent_count    = 0;
	int unsigned rx_gap_pct    = GAP_PCT;
	int unsigned sink_gap_pct  = GAP_PCT;
	logic        hold_requested = 1'b0;
	logic [7:0]  outgoing [$];

	always #2 clk = ~clk;

	marker_framed_csv_integer_parser_top #(
		.MAX_CONTENT_CHARS(CONTENT_CHARS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_ready       (rx_ready),
		.rx_byte        (rx_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.throttle_value (throttle_value),
		.pitch_value    (pitch_value),
		.yaw_value      (yaw_value),
		.roll_value     (roll_value),
		.pieces_found   (pieces_found)
	);

	mfcip_frame_checker #(
		.MAX_CONTENT_CHARS(CONTENT_CHARS)
	) checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.rx_valid           (rx_valid),
		.rx_ready           (rx_ready),
		.rx_byte            (rx_byte),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.throttle_value     (throttle_value),
		.pitch_value        (pitch_value),
		.yaw_value          (yaw_value),
		.roll_value         (roll_value),
		.pieces_found       (pieces_found),
		.mismatch_count     (mismatch_count),
		.frames_outstanding (frames_outstanding)
	);

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Drive result_ready; hold it low for a long stretch once asked
	initial begin : result_sink
		int unsigned stall_left;
		logic        hold_taken;
		stall_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requested && !hold_taken) begin
				stall_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= sink_gap_pct);
			end
		end
	end

	// Offer one byte and hold it until the transaction completes
	task automatic send_byte(input logic [7:0] value);
		logic taken;
		while ($urandom_range(99) < rx_gap_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = rx_ready;
			@(posedge clk);
		end
	endtask

	task automatic send_outgoing();
		while (outgoing.size() != 0) begin
			send_byte(outgoing.pop_front());
			sent_count++;
		end
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			outgoing.push_back(s[i]);
	endtask

	// Mostly well-formed frame with random pieces, sometimes broken
	task automatic push_random_frame();
		int unsigned pieces;
		int unsigned digits;
		outgoing.push_back(CH_START);
		pieces = $urandom_range(0, 6);
		for (int p = 0; p < pieces; p++) begin
			if (p != 0 || $urandom_range(5) == 0)
				repeat ($urandom_range(1, 2)) outgoing.push_back(CH_COMMA);
			repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
				outgoing.push_back($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
			case ($urandom_range(3))
				0: outgoing.push_back(CH_PLUS);
				1: outgoing.push_back(CH_MINUS);
				default: begin
				end
			endcase
			digits = $urandom_range(7) == 0 ? 0 : $urandom_range(1, 6);
			repeat (digits) outgoing.push_back(8'(CH_ZERO + $urandom_range(9)));
			if ($urandom_range(7) == 0)
				outgoing.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		// early terminator, overlong content, raw byte, missing end marker
		if ($urandom_range(9) == 0) begin
			outgoing.push_back(CH_NUL);
			repeat ($urandom_range(1, 3)) outgoing.push_back(8'(CH_ZERO + $urandom_range(9)));
		end
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(20, 35))
				outgoing.push_back($urandom_range(4) == 0 ? CH_COMMA :
					8'(CH_ZERO + $urandom_range(9)));
		if ($urandom_range(11) == 0)
			outgoing.push_back(8'($urandom_range(255)));
		if ($urandom_range(14) != 0)
			outgoing.push_back(CH_END);
	endtask

	task automatic run_random(input int unsigned upto);
		while (sent_count < upto) begin
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 4)) outgoing.push_back(8'($urandom_range(255)));
			push_random_frame();
			send_outgoing();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// noise outside a frame, then an empty frame
		push_text("Z<>");
		// exact minimum, positive clip, empty piece, pieces without digits,
		// start marker as content, fifth piece dropped
		push_text("<-32768,+40000,,x,<,5>");
		// blank before digits, sign then blank, negative clip, zero terminator
		push_text("< 7,- 3,-99999");
		outgoing.push_back(CH_NUL);
		push_text("9,9>");
		send_outgoing();

		run_random(250);

		// back-to-back frames against a held-off receiver
		rx_gap_pct = 0;
		sink_gap_pct = 0;
		hold_requested = 1'b1;
		repeat (25) begin
			outgoing.push_back(CH_START);
			outgoing.push_back(8'(CH_ZERO + $urandom_range(9)));
			outgoing.push_back(CH_END);
		end
		send_outgoing();
		run_random(450);

		rx_gap_pct = GAP_PCT;
		sink_gap_pct = GAP_PCT;
		run_random(750);
		rx_valid <= 1'b0;

		// drain outstanding frames, then let the pipeline settle
		@(negedge clk);
		while (frames_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
